// ----- src/max_pool_2d_channels_last_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the max pooling block
// Short forms for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef MAX_POOL_2D_CHANNELS_LAST_MACROS_SVH
`define MAX_POOL_2D_CHANNELS_LAST_MACROS_SVH

// same-cycle implication
`define MP2D_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mp2d check failed");

// next-cycle implication
`define MP2D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mp2d check failed");

`endif

// ----- src/mp2d_pkg.sv -----
// ----------------------------------------------------------------------------
// mp2d_pkg
// Field widths, stream layout and register codes of the max pooling block.
// ----------------------------------------------------------------------------
`default_nettype none

package mp2d_pkg;

	// input item fields
	localparam int LOAD_ADDR_W  = 12;
	localparam int LOAD_VALUE_W = 32;
	localparam int POS_FIELD_W  = 6;
	localparam int S_TDATA_W    = 64;

	// result item fields
	localparam int MAX_VALUE_W  = 32;
	localparam int MAX_INDEX_W  = 12;
	localparam int M_TDATA_W    = 48;

	// configuration port
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 8;
	localparam int DIM_W        = 7;
	localparam int WIN_FIELD_W  = 4;
	localparam int NIB_W        = 4;

	// signed window position: 63*15 plus 15 steps of 15 stays below 2048
	localparam int POS_W        = 12;
	// row*W + col within a 127x127 image
	localparam int RC_W         = 2 * DIM_W;
	// (row*W + col)*C + channel
	localparam int IDX_W        = 21;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_HEIGHT  = 3'd0,
		REG_IMAGE_WIDTH   = 3'd1,
		REG_CHANNEL_COUNT = 3'd2,
		REG_WINDOW_HEIGHT = 3'd3,
		REG_WINDOW_WIDTH  = 3'd4,
		REG_STRIDE_PAIR   = 3'd5,
		REG_PADDING_PAIR  = 3'd6,
		REG_DILATION_PAIR = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

endpackage

`default_nettype wire

// ----- src/mp2d_ram.sv -----
// ----------------------------------------------------------------------------
// mp2d_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2d_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- src/max_pool_2d_channels_last.sv -----
// A query walks its window, one window position per cycle, with one read of the
// store's read port for each position inside the image; the block then drains
// the address pipeline, the store read and the compare before the result goes
// to the output register. RED_N is 0 when STORE_DEPTH is a power of two and
// 22 - clog2(STORE_DEPTH) otherwise: one compare-and-subtract stage per
// quotient bit reduces the element index modulo the depth. A load carries its
// value down the reduction stages of the same address pipeline and is written
// from the last of them; the input takes the next item once the load has
// drained, and store accesses stay in order. One query is in work at a time; a
// finished result waits in the output register while the next item is taken,
// and a query only stalls at its end if the previous result is unread.
// ----------------------------------------------------------------------------
// max_pool_2d_channels_last
// Channels-last 2-D max pooling with argmax over an image held in block RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_2d_channels_last import mp2d_pkg::*; #(
	parameter int STORE_DEPTH = 4096,
	parameter int VALUE_BITS  = 32,
	parameter int MAX_WINDOW  = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration writes
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// input stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// load_address[11:0], load_value[43:12], out_row[49:44], out_col[55:50],
	// out_channel[61:56], zero[63:62]
	input  wire logic [S_TDATA_W-1:0]   s_tdata,
	// opcode[0]
	input  wire logic                   s_tuser,
	// result stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// peak_value[31:0], peak_index[43:32], zero[47:44]
	output logic      [M_TDATA_W-1:0]   m_tdata,
	// window_empty[0]
	output logic                        m_tuser
);

	localparam int ADDR_W     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam bit DEPTH_POW2 = (STORE_DEPTH == (1 << ADDR_W));
	localparam int RED_N      = DEPTH_POW2 ? 0 :
	                            ((IDX_W >= ADDR_W) ? IDX_W - ADDR_W + 1 : 0);
	localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
	localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(STORE_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	// payload of one address pipeline stage
	typedef struct packed {
		logic                   wr;
		logic [MAX_INDEX_W-1:0] idx;
		logic [IDX_W-1:0]       rem;
		logic [VALUE_BITS-1:0]  val;
	} pipe_t;

	function automatic logic [NIB_W-1:0] nz(input logic [NIB_W-1:0] v);
		return (v == '0) ? NIB_W'(1) : v;
	endfunction

	function automatic logic [WIN_W-1:0] clip_win(input logic [WIN_FIELD_W-1:0] k);
		return (int'(k) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : WIN_W'(k);
	endfunction

	// configuration registers
	logic [DIM_W-1:0]       img_h_q, img_w_q, chan_cnt_q;
	logic [WIN_FIELD_W-1:0] win_h_q, win_w_q;
	logic [CFG_DATA_W-1:0]  stride_q, pad_q, dil_q;

	state_t                 state_q;
	opcode_t                op_q;
	logic [POS_W-1:0]       row_q, col_q, col0_q;
	logic [WIN_W-1:0]       a_q, b_q;
	logic [POS_FIELD_W-1:0] ch_q;

	logic                   vld_s1;
	logic [RC_W-1:0]        rc_s1;
	logic [RED_N:0]         vld_s2;
	pipe_t                  pipe_s2 [RED_N+1];
	logic                   vld_rd_q;
	logic [MAX_INDEX_W-1:0] idx_rd_q;

	logic                   found_q;
	logic [VALUE_BITS-1:0]  best_q;
	logic [MAX_INDEX_W-1:0] best_idx_q;

	logic                   out_valid_q;
	logic [MAX_VALUE_W-1:0] out_value_q;
	logic [MAX_INDEX_W-1:0] out_index_q;
	logic                   out_empty_q;

	// input fields
	logic [LOAD_ADDR_W-1:0]  ld_addr;
	logic [LOAD_VALUE_W-1:0] ld_value;
	logic [POS_FIELD_W-1:0]  in_row, in_col, in_ch;
	opcode_t                 in_op;

	assign ld_addr  = s_tdata[11:0];
	assign ld_value = s_tdata[43:12];
	assign in_row   = s_tdata[49:44];
	assign in_col   = s_tdata[55:50];
	assign in_ch    = s_tdata[61:56];
	assign in_op    = opcode_t'(s_tuser);

	// effective window geometry
	logic [NIB_W-1:0] sh, sw, ph, pw, dh, dw;
	logic [WIN_W-1:0] kh, kw;

	assign sh = nz(stride_q[7:4]);
	assign sw = nz(stride_q[3:0]);
	assign ph = pad_q[7:4];
	assign pw = pad_q[3:0];
	assign dh = nz(dil_q[7:4]);
	assign dw = nz(dil_q[3:0]);
	assign kh = clip_win(win_h_q);
	assign kw = clip_win(win_w_q);

	// window origin of the asked-for output position
	logic [POS_FIELD_W+NIB_W-1:0] r_prod, c_prod;
	logic [POS_W-1:0]             r0, c0;

	assign r_prod = (POS_FIELD_W+NIB_W)'(in_row) * (POS_FIELD_W+NIB_W)'(sh);
	assign c_prod = (POS_FIELD_W+NIB_W)'(in_col) * (POS_FIELD_W+NIB_W)'(sw);
	assign r0     = POS_W'(r_prod) - POS_W'(ph);
	assign c0     = POS_W'(c_prod) - POS_W'(pw);

	logic in_xfer, q_start, row_in, col_in, emit, last_col, last_row;
	logic busy, finish;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign q_start  = in_xfer && (in_op == OP_QUERY);

	// clip to the image; bit POS_W-1 is the sign
	assign row_in   = !row_q[POS_W-1] && (row_q[POS_W-2:0] < (POS_W-1)'(img_h_q));
	assign col_in   = !col_q[POS_W-1] && (col_q[POS_W-2:0] < (POS_W-1)'(img_w_q));
	assign emit     = (state_q == ST_SCAN) && row_in && col_in;
	assign last_col = (WIN_W'(b_q + 1'b1) == kw);
	assign last_row = (WIN_W'(a_q + 1'b1) == kh);

	assign busy     = vld_s1 || (|vld_s2) || vld_rd_q;
	assign finish   = (state_q == ST_DRAIN) && !busy &&
	                  (op_q == OP_LOAD || !out_valid_q || m_tready);

	// configuration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_h_q    <= DIM_W'(1);
			img_w_q    <= DIM_W'(1);
			chan_cnt_q <= DIM_W'(1);
			win_h_q    <= WIN_FIELD_W'(1);
			win_w_q    <= WIN_FIELD_W'(1);
			stride_q   <= 8'h11;
			pad_q      <= 8'h00;
			dil_q      <= 8'h11;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_HEIGHT:  img_h_q    <= cfg_data[DIM_W-1:0];
				REG_IMAGE_WIDTH:   img_w_q    <= cfg_data[DIM_W-1:0];
				REG_CHANNEL_COUNT: chan_cnt_q <= cfg_data[DIM_W-1:0];
				REG_WINDOW_HEIGHT: win_h_q    <= cfg_data[WIN_FIELD_W-1:0];
				REG_WINDOW_WIDTH:  win_w_q    <= cfg_data[WIN_FIELD_W-1:0];
				REG_STRIDE_PAIR:   stride_q   <= cfg_data;
				REG_PADDING_PAIR:  pad_q      <= cfg_data;
				REG_DILATION_PAIR: dil_q      <= cfg_data;
			endcase
		end
	end

	// sequencer: accept, walk the window row by row for a query, drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_LOAD;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						op_q <= in_op;
						if (in_op == OP_QUERY && kh != '0 && kw != '0) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_SCAN: begin
					if (last_col && last_row) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// window position counters
	always_ff @(posedge clk) begin
		if (q_start) begin
			row_q  <= r0;
			col_q  <= c0;
			col0_q <= c0;
			a_q    <= '0;
			b_q    <= '0;
			ch_q   <= in_ch;
		end else if (state_q == ST_SCAN) begin
			if (last_col) begin
				b_q   <= '0;
				col_q <= col0_q;
				a_q   <= WIN_W'(a_q + 1'b1);
				row_q <= row_q + POS_W'(dh);
			end else begin
				b_q   <= WIN_W'(b_q + 1'b1);
				col_q <= col_q + POS_W'(dw);
			end
		end
	end

	// stage 1: row*W + col
	logic [RC_W-1:0] rw_prod;
	assign rw_prod = RC_W'(row_q[DIM_W-1:0]) * RC_W'(img_w_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		rc_s1 <= rw_prod + RC_W'(col_q[DIM_W-1:0]);
	end

	// stage 2: full index, then one compare-and-subtract per reduction stage
	logic [IDX_W-1:0] idx_prod, idx_full;
	logic             ld_xfer;

	assign idx_prod = IDX_W'(rc_s1) * IDX_W'(chan_cnt_q);
	assign idx_full = idx_prod + IDX_W'(ch_q);
	assign ld_xfer  = in_xfer && (in_op == OP_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= '0;
		end else begin
			vld_s2[0] <= vld_s1 || ld_xfer;
			for (int k = 1; k <= RED_N; k++) begin
				vld_s2[k] <= vld_s2[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_xfer) begin
			pipe_s2[0].wr  <= 1'b1;
			pipe_s2[0].idx <= '0;
			pipe_s2[0].rem <= IDX_W'(ld_addr);
		end else begin
			pipe_s2[0].wr  <= 1'b0;
			pipe_s2[0].idx <= idx_full[MAX_INDEX_W-1:0];
			pipe_s2[0].rem <= idx_full;
		end
		pipe_s2[0].val <= VALUE_BITS'($signed(ld_value));
		for (int k = 1; k <= RED_N; k++) begin
			pipe_s2[k].wr  <= pipe_s2[k-1].wr;
			pipe_s2[k].idx <= pipe_s2[k-1].idx;
			pipe_s2[k].val <= pipe_s2[k-1].val;
			if (pipe_s2[k-1].rem >= (DEPTH_IDX << (RED_N - k))) begin
				pipe_s2[k].rem <= pipe_s2[k-1].rem - (DEPTH_IDX << (RED_N - k));
			end else begin
				pipe_s2[k].rem <= pipe_s2[k-1].rem;
			end
		end
	end

	// image store; each stage carries either a load or a read, never both
	logic                  ram_we, ram_re;
	logic [ADDR_W-1:0]     ram_addr;
	logic [VALUE_BITS-1:0] ram_rdata;

	assign ram_addr = pipe_s2[RED_N].rem[ADDR_W-1:0];
	assign ram_we   = vld_s2[RED_N] && pipe_s2[RED_N].wr;
	assign ram_re   = vld_s2[RED_N] && !pipe_s2[RED_N].wr;

	mp2d_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (pipe_s2[RED_N].val),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_rd_q <= 1'b0;
		end else begin
			vld_rd_q <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		idx_rd_q <= pipe_s2[RED_N].idx;
	end

	// running maximum; strict compare keeps the earliest on ties
	logic take;
	assign take = vld_rd_q && (!found_q || ($signed(ram_rdata) > $signed(best_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (q_start) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q     <= ram_rdata;
			best_idx_q <= idx_rd_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish && op_q == OP_QUERY) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish && op_q == OP_QUERY) begin
			out_value_q <= found_q ? MAX_VALUE_W'($signed(best_q)) : '0;
			out_index_q <= found_q ? best_idx_q : '0;
			out_empty_q <= !found_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'({out_index_q, out_value_q});
	assign m_tuser  = out_empty_q;

endmodule

`default_nettype wire

// ----- src/mp2d_checker.sv -----
// ----------------------------------------------------------------------------
// mp2d_checker
// Port-level checks of the max pooling block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_pool_2d_channels_last_macros.svh"

module mp2d_checker import mp2d_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic                 m_tuser
);

	// a stalled result holds
	`MP2D_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// an empty window reports zero value and index
	`MP2D_ASSERT_IMPL(a_empty_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0)

	// one item in work at a time
	`MP2D_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// padding above the index stays clear
	`MP2D_ASSERT_IMPL(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[M_TDATA_W-1:MAX_VALUE_W+MAX_INDEX_W] == '0)

endmodule

bind max_pool_2d_channels_last mp2d_checker u_mp2d_checker (.*);

`default_nettype wire
